// ===== rtl/rqs_pkg.sv =====
// shared types, register indexes and constants of the requantizer
package rqs_pkg;

    localparam int RQS_MAX_CHANNELS = 256;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_ZERO_POINT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_ZERO_POINT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_ENABLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_MODE     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE      = 3'd7;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic LAYOUT_INTERLEAVED = 1'b0;
    localparam logic LAYOUT_PLANAR      = 1'b1;

    typedef struct packed {
        logic        [4:0]  shift_amount;
        logic signed [31:0] in_zero_point;
        logic signed [31:0] out_zero_point;
        logic signed [7:0]  clamp_low;
        logic signed [7:0]  clamp_high;
        logic               round_enable;
        logic               layout_mode;
        logic        [15:0] group_size;
    } t_cfg;

    typedef struct packed {
        logic        [31:0] multiplier;
        logic        [31:0] addend;
    } t_coeff;

endpackage

// ===== rtl/rqs_cfg_regs.sv =====
// configuration register bank
module rqs_cfg_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rqs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rqs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output rqs_pkg::t_cfg                   o_cfg
);

    rqs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift_amount   <= 5'd0;
            r_cfg.in_zero_point  <= 32'sd0;
            r_cfg.out_zero_point <= 32'sd0;
            r_cfg.clamp_low      <= -8'sd128;
            r_cfg.clamp_high     <= 8'sd127;
            r_cfg.round_enable   <= 1'b0;
            r_cfg.layout_mode    <= rqs_pkg::LAYOUT_INTERLEAVED;
            r_cfg.group_size     <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rqs_pkg::CFG_SHIFT_AMOUNT:   r_cfg.shift_amount   <= i_cfg_data[4:0];
                rqs_pkg::CFG_IN_ZERO_POINT:  r_cfg.in_zero_point  <= i_cfg_data;
                rqs_pkg::CFG_OUT_ZERO_POINT: r_cfg.out_zero_point <= i_cfg_data;
                rqs_pkg::CFG_CLAMP_LOW:      r_cfg.clamp_low      <= i_cfg_data[7:0];
                rqs_pkg::CFG_CLAMP_HIGH:     r_cfg.clamp_high     <= i_cfg_data[7:0];
                rqs_pkg::CFG_ROUND_ENABLE:   r_cfg.round_enable   <= i_cfg_data[0];
                rqs_pkg::CFG_LAYOUT_MODE:    r_cfg.layout_mode    <= i_cfg_data[0];
                rqs_pkg::CFG_GROUP_SIZE:     r_cfg.group_size     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/rqs_chan_ctr.sv =====
// element position and plane counters that select the coefficient entry
module rqs_chan_ctr #(
    parameter int MAX_CHANNELS = rqs_pkg::RQS_MAX_CHANNELS,
    parameter int AW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic            i_tensor_start,
    input  rqs_pkg::t_cfg   i_cfg,
    output logic [AW-1:0]   o_addr
);

    localparam logic [AW:0] ChanLimit = (AW+1)'(MAX_CHANNELS);

    logic [15:0]   r_pos;
    logic [7:0]    r_chan;
    logic [AW-1:0] r_pos_mod;
    logic [AW-1:0] r_chan_mod;

    logic [15:0]   pos_cur;
    logic [7:0]    chan_cur;
    logic [AW-1:0] pos_mod_cur;
    logic [AW-1:0] chan_mod_cur;
    logic [15:0]   pos_inc;
    logic [15:0]   limit;
    logic          wrap;
    logic [AW:0]   pos_mod_inc;
    logic [AW:0]   chan_mod_inc;
    logic [15:0]   n_pos;
    logic [7:0]    n_chan;
    logic [AW-1:0] n_pos_mod;
    logic [AW-1:0] n_chan_mod;

    always_comb begin
        pos_cur      = i_tensor_start ? 16'd0 : r_pos;
        chan_cur     = i_tensor_start ? 8'd0 : r_chan;
        pos_mod_cur  = i_tensor_start ? '0 : r_pos_mod;
        chan_mod_cur = i_tensor_start ? '0 : r_chan_mod;

        o_addr = (i_cfg.layout_mode == rqs_pkg::LAYOUT_PLANAR) ? chan_mod_cur : pos_mod_cur;

        limit        = (i_cfg.group_size == 16'd0) ? 16'd1 : i_cfg.group_size;
        pos_inc      = pos_cur + 16'd1;
        wrap         = (pos_inc >= limit);
        pos_mod_inc  = {1'b0, pos_mod_cur} + (AW+1)'(1);
        chan_mod_inc = {1'b0, chan_mod_cur} + (AW+1)'(1);

        n_pos  = wrap ? 16'd0 : pos_inc;
        n_chan = wrap ? chan_cur + 8'd1 : chan_cur;

        if (n_pos == 16'd0) begin
            n_pos_mod = '0;
        end else begin
            n_pos_mod = (pos_mod_inc == ChanLimit) ? '0 : pos_mod_inc[AW-1:0];
        end

        if (!wrap) begin
            n_chan_mod = chan_mod_cur;
        end else if (chan_cur == 8'hFF) begin
            n_chan_mod = '0;
        end else begin
            n_chan_mod = (chan_mod_inc == ChanLimit) ? '0 : chan_mod_inc[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= 16'd0;
            r_chan     <= 8'd0;
            r_pos_mod  <= '0;
            r_chan_mod <= '0;
        end else if (i_step) begin
            r_pos      <= n_pos;
            r_chan     <= n_chan;
            r_pos_mod  <= n_pos_mod;
            r_chan_mod <= n_chan_mod;
        end
    end

endmodule

// ===== rtl/rqs_coeff_mem.sv =====
// per-channel multiplier and addend memory, one write and one registered read port
module rqs_coeff_mem #(
    parameter int MAX_CHANNELS = rqs_pkg::RQS_MAX_CHANNELS,
    parameter int AW           = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [7:0]      i_slot,
    input  rqs_pkg::t_coeff i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output rqs_pkg::t_coeff o_rdata
);

    typedef logic [AW-1:0] t_slot_map [256];

    function automatic t_slot_map f_slot_map();
        t_slot_map map;
        int        m;
        m = 0;
        for (int i = 0; i < 256; i++) begin
            map[i] = AW'(m);
            m = (m + 1 == MAX_CHANNELS) ? 0 : m + 1;
        end
        return map;
    endfunction

    localparam t_slot_map SlotMap = f_slot_map();

    rqs_pkg::t_coeff r_mem [MAX_CHANNELS];
    rqs_pkg::t_coeff r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[SlotMap[i_slot]] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rqs_datapath.sv =====
// multiply, add, round, shift, offset and clamp pipeline with output register
module rqs_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rqs_pkg::t_cfg       i_cfg,
    input  logic                i_take,
    input  logic signed [31:0]  i_sample,
    input  rqs_pkg::t_coeff     i_coeff,
    output logic                o_advance,
    output logic                o_valid,
    input  logic                i_ready,
    output logic signed [7:0]   o_quantized
);

    logic               r_v1;
    logic               r_v2;
    logic               r_v3;
    logic               r_v4;
    logic               r_ov;
    logic        [31:0] r_x1;
    logic        [31:0] r_prod2;
    logic        [31:0] r_add2;
    logic        [31:0] r_sum3;
    logic signed [31:0] r_y4;
    logic signed [7:0]  r_q;

    logic               adv;
    logic        [31:0] rnd;
    logic signed [31:0] shifted;
    logic signed [31:0] lo_ext;
    logic signed [31:0] hi_ext;
    logic signed [7:0]  n_q;

    assign adv = !r_ov || i_ready;

    always_comb begin
        if (i_cfg.round_enable && (i_cfg.shift_amount != 5'd0)) begin
            rnd = 32'd1 << (i_cfg.shift_amount - 5'd1);
        end else begin
            rnd = 32'd0;
        end
        shifted = $signed(r_sum3) >>> i_cfg.shift_amount;
        lo_ext  = 32'(i_cfg.clamp_low);
        hi_ext  = 32'(i_cfg.clamp_high);
        priority if (r_y4 < lo_ext) begin
            n_q = i_cfg.clamp_low;
        end else if (r_y4 > hi_ext) begin
            n_q = i_cfg.clamp_high;
        end else begin
            n_q = r_y4[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x1    <= i_sample + i_cfg.in_zero_point;
            r_prod2 <= r_x1 * i_coeff.multiplier;
            r_add2  <= i_coeff.addend;
            r_sum3  <= r_prod2 + r_add2 + rnd;
            r_y4    <= shifted + i_cfg.out_zero_point;
            r_q     <= n_q;
        end
    end

    assign o_advance   = adv;
    assign o_valid     = r_ov;
    assign o_quantized = r_q;

endmodule

// ===== rtl/per_channel_requantize_shift_top.sv =====
// datapath: an accepted data transfer passes the input offset, product, sum, shift and clamp registers in order
// throughput: one item per cycle, loads and samples alike; the five-stage
// pipeline with a single coefficient memory read stalls only on output backpressure
// reset: synchronous active low; clears configuration, element counters and stage valids;
// the coefficient memory is not cleared and must be loaded before use
module per_channel_requantize_shift_top #(
    parameter int MAX_CHANNELS = rqs_pkg::RQS_MAX_CHANNELS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rqs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rqs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic        [7:0]               i_coeff_slot,
    input  logic signed [31:0]              i_multiplier_value,
    input  logic signed [31:0]              i_addend_value,
    input  logic signed [31:0]              i_sample,
    input  logic                            i_tensor_start,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [7:0]               o_quantized
);

    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    rqs_pkg::t_cfg   cfg;
    rqs_pkg::t_coeff wdata;
    rqs_pkg::t_coeff rdata;
    logic            advance;
    logic            in_xfer;
    logic            load_xfer;
    logic            data_xfer;
    logic [AW-1:0]   raddr;

    assign o_in_ready = advance;
    assign in_xfer    = i_in_valid && advance;
    assign load_xfer  = in_xfer && (i_operation == rqs_pkg::OP_LOAD);
    assign data_xfer  = in_xfer && (i_operation == rqs_pkg::OP_DATA);

    assign wdata.multiplier = i_multiplier_value;
    assign wdata.addend     = i_addend_value;

    rqs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rqs_chan_ctr #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_ctr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (data_xfer),
        .i_tensor_start (i_tensor_start),
        .i_cfg          (cfg),
        .o_addr         (raddr)
    );

    rqs_coeff_mem #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .AW           (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (load_xfer),
        .i_slot  (i_coeff_slot),
        .i_wdata (wdata),
        .i_re    (advance),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    rqs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_take      (data_xfer),
        .i_sample    (i_sample),
        .i_coeff     (rdata),
        .o_advance   (advance),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_quantized (o_quantized)
    );

endmodule
